// File: rtl/cmma_pkg.sv
package cmma_pkg;

    // Field widths of the bus item and of the result.
    localparam int ADDR_W = 24;
    localparam int DATA_W = 8;
    localparam int SIZE_W = 19;
    localparam int OFF_W  = 18;
    localparam int REQ_W  = 2;
    localparam int CFG_IDX_W = 2;

    // Store depths and the address widths that follow from them.
    localparam int PRG_BYTES = 262144;
    localparam int CHR_BYTES = 262144;
    localparam int PRG_AW = $clog2(PRG_BYTES);
    localparam int CHR_AW = $clog2(CHR_BYTES);

    // Weight of the highest address bit, where the fold starts.
    localparam logic [ADDR_W-1:0] TOP_ADDR_BIT = ADDR_W'(1) << (ADDR_W - 1);

    // Access kinds carried in tuser.
    localparam logic [REQ_W-1:0] REQ_PRG_READ  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PRG_WRITE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CHR_READ  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CHR_WRITE = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PRG_SPAN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_SPAN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_WRITABLE = 2'd2;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [SIZE_W-1:0] size_t;
    typedef logic [DATA_W-1:0] byte_t;

endpackage

// File: rtl/cartridge_mirrored_memory_access.sv
// Cartridge bus access with address mirroring into program and character
// stores of configurable span. Each item carries the access kind in s_tuser
// and the address and write byte in s_tdata; each accepted item gives
// exactly one result with the byte read (zero for writes) and the mirrored
// offset. The address is folded one bit per cycle, from bit 23 down to
// bit 0. The accepting edge also loads the folder; after the fold the done
// flag is registered, the store is accessed, and the registered read data
// is loaded into the output register with the result. The block takes the
// next item only after that, so it never holds two items at once. A result
// waiting at the output does not hold off the next item, which stalls only
// if it finishes before the waiting result is taken. Size and write-enable
// registers must be written by the user through the cfg port only while no
// item is in flight; the block itself does not enforce this.
module cartridge_mirrored_memory_access (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cmma_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cmma_pkg::SIZE_W-1:0]       cfg_data,
    // Access items.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,  // bus_address[23:0], write_data[31:24]
    input  logic [cmma_pkg::REQ_W-1:0]        s_tuser,  // req_type[1:0]
    // Result items.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata   // read_data[7:0], mapped_offset[25:8], zero
);
    import cmma_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_FOLD   = 2'd1;
    localparam logic [1:0] ST_ACCESS = 2'd2;
    localparam logic [1:0] ST_RESP   = 2'd3;

    logic [1:0] state_reg, state_next;

    size_t prg_span_reg, prg_span_next;
    size_t chr_span_reg, chr_span_next;
    logic  chr_wr_reg, chr_wr_next;

    logic  is_chr_reg, is_chr_next;
    logic  is_write_reg, is_write_next;
    byte_t wdata_reg, wdata_next;
    logic  hit_reg, hit_next;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg, out_data_next;

    logic  accept;
    logic  req_chr;
    logic  fold_done;
    addr_t offset;
    logic  in_prg;
    logic  in_chr;
    logic  prg_en;
    logic  prg_we;
    logic  chr_en;
    logic  chr_we;
    byte_t prg_q;
    byte_t chr_q;
    byte_t rd_byte;
    logic  out_free;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign req_chr   = (s_tuser == REQ_CHR_READ) || (s_tuser == REQ_CHR_WRITE);

    // Configuration register writes; unknown indexes are dropped.
    always_comb
    begin
        prg_span_next = prg_span_reg;
        chr_span_next = chr_span_reg;
        chr_wr_next   = chr_wr_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PRG_SPAN:     prg_span_next = cfg_data;
                CFG_CHR_SPAN:     chr_span_next = cfg_data;
                CFG_CHR_WRITABLE: chr_wr_next   = cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Serial address folder.
    cmma_fold u_fold (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept),
        .address (s_tdata[ADDR_W-1:0]),
        .region  (req_chr ? chr_span_reg : prg_span_reg),
        .done    (fold_done),
        .offset  (offset)
    );

    // Store access: out-of-range offsets read as zero and drop writes.
    assign in_prg = offset < ADDR_W'(PRG_BYTES);
    assign in_chr = offset < ADDR_W'(CHR_BYTES);
    assign prg_en = (state_reg == ST_ACCESS) && !is_chr_reg && in_prg;
    assign prg_we = is_write_reg;
    assign chr_en = (state_reg == ST_ACCESS) && is_chr_reg && in_chr
                    && (!is_write_reg || chr_wr_reg);
    assign chr_we = is_write_reg;

    cmma_ram #(
        .WIDTH (DATA_W),
        .DEPTH (PRG_BYTES)
    ) u_prg_ram (
        .clk   (clk),
        .en    (prg_en),
        .we    (prg_we),
        .addr  (offset[PRG_AW-1:0]),
        .wdata (wdata_reg),
        .rdata (prg_q)
    );

    cmma_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CHR_BYTES)
    ) u_chr_ram (
        .clk   (clk),
        .en    (chr_en),
        .we    (chr_we),
        .addr  (offset[CHR_AW-1:0]),
        .wdata (wdata_reg),
        .rdata (chr_q)
    );

    assign rd_byte  = hit_reg ? (is_chr_reg ? chr_q : prg_q) : '0;
    assign out_free = !out_valid_reg || m_tready;

    // Sequencer for one item and the output register.
    always_comb
    begin
        state_next     = state_reg;
        is_chr_next    = is_chr_reg;
        is_write_next  = is_write_reg;
        wdata_next     = wdata_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    is_chr_next   = req_chr;
                    is_write_next = (s_tuser == REQ_PRG_WRITE)
                                    || (s_tuser == REQ_CHR_WRITE);
                    wdata_next    = s_tdata[ADDR_W+DATA_W-1:ADDR_W];
                    state_next    = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                if (fold_done)
                begin
                    state_next = ST_ACCESS;
                end
            end
            ST_ACCESS:
            begin
                hit_next   = !is_write_reg && (is_chr_reg ? in_chr : in_prg);
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {6'd0, offset[OFF_W-1:0], rd_byte};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prg_span_reg  <= '0;
            chr_span_reg  <= '0;
            chr_wr_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prg_span_reg  <= prg_span_next;
            chr_span_reg  <= chr_span_next;
            chr_wr_reg    <= chr_wr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_chr_reg   <= is_chr_next;
        is_write_reg <= is_write_next;
        wdata_reg    <= wdata_next;
        hit_reg      <= hit_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef NO_ASSERTIONS
    a_fold_done_in_fold: assert property (@(posedge clk) disable iff (!rst_n)
        fold_done |-> (state_reg == ST_FOLD))
        else $error("fold finished outside the fold state");

    a_one_store: assert property (@(posedge clk) disable iff (!rst_n)
        !(prg_en && chr_en))
        else $error("both stores enabled at once");

    a_resp_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> $stable(out_data_reg))
        else $error("waiting result was overwritten");
`endif

endmodule

// File: rtl/cmma_ram.sv
module cmma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single port: write or registered read.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/cmma_fold.sv
module cmma_fold (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  cmma_pkg::addr_t address,
    input  cmma_pkg::size_t region,
    output logic            done,
    output cmma_pkg::addr_t offset
);
    import cmma_pkg::*;

    logic  busy_reg, busy_next;
    logic  done_reg, done_next;
    addr_t bit_reg, bit_next;
    addr_t a_reg, a_next;
    addr_t base_reg, base_next;
    size_t region_reg, region_next;

    logic  above;
    logic  hit;
    logic  move;

    // One address bit per cycle, from the top down. The one-hot weight
    // shifts right each cycle and marks the bit under inspection.
    always_comb
    begin
        above = a_reg >= ADDR_W'(region_reg);
        hit   = busy_reg && above && ((a_reg & bit_reg) != '0);
        move  = hit && (ADDR_W'(region_reg) > bit_reg);

        busy_next   = busy_reg;
        done_next   = 1'b0;
        bit_next    = bit_reg;
        a_next      = a_reg;
        base_next   = base_reg;
        region_next = region_reg;

        if (start)
        begin
            busy_next   = 1'b1;
            bit_next    = TOP_ADDR_BIT;
            a_next      = address;
            base_next   = '0;
            region_next = region;
        end
        else if (busy_reg)
        begin
            // If a_reg >= region, drop the bit; move it to base if region > bit.
            if (hit)
            begin
                a_next = a_reg & ~bit_reg;
            end
            if (move)
            begin
                region_next = region_reg - bit_reg[SIZE_W-1:0];
                base_next   = base_reg | bit_reg;
            end
            bit_next = bit_reg >> 1;
            if (bit_reg[0])
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg    <= bit_next;
        a_reg      <= a_next;
        base_reg   <= base_next;
        region_reg <= region_next;
    end

    // Base and remaining address never share a bit, so OR is the sum.
    assign offset = base_reg | a_reg;
    assign done   = done_reg;

`ifndef NO_ASSERTIONS
    a_onehot_bit: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> $onehot(bit_reg))
        else $error("fold weight is not one-hot");

    a_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg || done_reg) |-> ((a_reg & base_reg) == '0))
        else $error("base and address overlap");

    // While the address is still not below the region, every higher bit is gone.
    a_high_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && above) |-> ((a_reg & ~((bit_reg << 1) - ADDR_W'(1))) == '0))
        else $error("address bit above the fold position is still set");

    a_region_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !start) |=> (region_reg <= $past(region_reg)))
        else $error("region grew during the fold");
`endif

endmodule
